[hw/rtl/tfd_pkg.sv]
// ----------------------------------------------------------------------------
// tfd_pkg
// types, constants and the address decode shared by the frame deframer
// ----------------------------------------------------------------------------
`default_nettype none

package tfd_pkg;

  localparam int unsigned WinDepth = 6;

  localparam logic [7:0]  DelimStart     = 8'hA5;
  localparam logic [7:0]  DelimEnd       = 8'h5A;
  localparam logic [7:0]  CmdWrite       = 8'h0A;
  localparam logic [15:0] VoltLimitReset = 16'd6000;
  localparam logic [3:0]  SlotInputVolt  = 4'd0;

  typedef struct packed {
    logic       hit;
    logic [3:0] slot;
  } slot_map_t;

  typedef struct packed {
    logic        delimiters_found;
    logic        checksum_good;
    logic        write_valid;
    logic [3:0]  target_slot;
    logic [15:0] slot_value;
  } result_t;

  function automatic slot_map_t slot_of_address(input logic [7:0] addr);
    slot_map_t m;
    logic [7:0] d;
    m = '0;
    d = '0;
    case (addr) inside
      [8'd8:8'd13]: begin
        d = addr - 8'd8;
        m.hit = 1'b1;
        m.slot = d[3:0];
      end
      [8'd16:8'd18]: begin
        d = addr - 8'd10;
        m.hit = 1'b1;
        m.slot = d[3:0];
      end
      default: begin
        m = '0;
      end
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/telemetry_frame_deframer_unit.sv]
// ----------------------------------------------------------------------------
// telemetry_frame_deframer_unit
// sliding seven-byte frame detector with checksum check and telemetry decode
// ----------------------------------------------------------------------------
// output: each accepted byte's result word is registered in the output or skid register
// throughput: one byte per cycle while the skid register is empty, set by the single
//   register stage and a two-deep output buffer (output register plus skid register)
// reset: synchronous; clears the byte window, the output and skid valid flags,
//   and loads the input voltage limit with 6000
`default_nettype none

module telemetry_frame_deframer_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // rx_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // target_slot[3:0], slot_value[19:4], zero pad
  output logic [2:0]       m_axis_tuser    // delimiters_found, checksum_good, write_valid
);

  logic [7:0]  win [tfd_pkg::WinDepth];
  logic [15:0] volt_limit;

  tfd_pkg::result_t res_next;
  tfd_pkg::result_t out_res;
  tfd_pkg::result_t skid_res;
  logic             out_valid;
  logic             skid_valid;

  logic             accept;
  logic             pop;
  logic [7:0]       sum;
  logic [15:0]      value;
  tfd_pkg::slot_map_t smap;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign pop    = m_axis_tvalid && m_axis_tready;

  assign s_axis_tready = !skid_valid;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'b0000, out_res.slot_value, out_res.target_slot};
  assign m_axis_tuser  = {out_res.write_valid, out_res.checksum_good,
                          out_res.delimiters_found};

  // frame decode on window plus the incoming byte
  always_comb begin
    sum   = win[1] + win[2] + win[3] + win[4];
    value = {win[4], win[3]};
    smap  = tfd_pkg::slot_of_address(win[2]);
    res_next = '0;
    if (win[0] == tfd_pkg::DelimStart && s_axis_tdata == tfd_pkg::DelimEnd) begin
      res_next.delimiters_found = 1'b1;
      if (win[5] == sum) begin
        res_next.checksum_good = 1'b1;
        if (win[1] == tfd_pkg::CmdWrite && smap.hit) begin
          res_next.write_valid = 1'b1;
          res_next.target_slot = smap.slot;
          if (smap.slot == tfd_pkg::SlotInputVolt && value > volt_limit) begin
            res_next.slot_value = '0;
          end else begin
            res_next.slot_value = value;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      volt_limit <= tfd_pkg::VoltLimitReset;
    end else if (cfg_we) begin
      volt_limit <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < tfd_pkg::WinDepth; i++) begin
        win[i] <= '0;
      end
    end else if (accept) begin
      for (int i = 0; i < tfd_pkg::WinDepth - 1; i++) begin
        win[i] <= win[i+1];
      end
      win[tfd_pkg::WinDepth-1] <= s_axis_tdata;
    end
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (accept) begin
      if (!out_valid || pop) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (!out_valid || pop) begin
        out_res <= res_next;
      end else begin
        skid_res <= res_next;
      end
    end else if (pop && skid_valid) begin
      out_res <= skid_res;
    end
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid word held while output register empty");

  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_axis_tready) |=> (out_valid && $stable(out_res)))
    else $error("stalled output word changed");

  a_write_implies_good: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.write_valid) |->
      (out_res.checksum_good && out_res.delimiters_found))
    else $error("write flagged without a good delimited frame");

  a_no_frame_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_res.write_valid) |->
      (out_res.target_slot == '0 && out_res.slot_value == '0))
    else $error("slot fields nonzero without a write");

endmodule

`default_nettype wire

[dv/telemetry_frame_deframer_unit_tb.sv]
// ----------------------------------------------------------------------------
// telemetry_frame_deframer_unit_tb
// feeds received bytes into the deframer and predicts every result word from
// a local copy of the six-byte window, comparing each word field by field
// across several input voltage limit settings with random stalls on both sides
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module telemetry_frame_deframer_unit_tb;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // rx_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // target_slot[3:0], slot_value[19:4], zero pad
  logic [2:0]  m_axis_tuser;        // delimiters_found, checksum_good, write_valid

  telemetry_frame_deframer_unit dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #2 clk = ~clk;

  logic [7:0]         pending_bytes [$];
  tfd_pkg::result_t   frame_results [$];
  tfd_pkg::result_t   want_word;
  logic [7:0]  rx_window [6] = '{default: '0};
  logic [15:0] vin_limit = tfd_pkg::VoltLimitReset;

  int unsigned idle_pct = 20;
  int unsigned src_gap = 0;
  int unsigned sink_gap = 0;
  int unsigned bytes_taken = 0;
  int unsigned words_checked = 0;
  int unsigned error_count = 0;
  int unsigned n_delim = 0;
  int unsigned n_good = 0;
  int unsigned n_write = 0;
  int unsigned n_clip = 0;
  int unsigned n_limits = 0;

  function automatic tfd_pkg::result_t deframe_byte(input logic [7:0] rx);
    tfd_pkg::result_t r;
    logic [7:0]  sum;
    logic [15:0] val;
    int          slot;
    r = '0;
    slot = -1;
    if (rx_window[0] == tfd_pkg::DelimStart && rx == tfd_pkg::DelimEnd) begin
      r.delimiters_found = 1'b1;
      n_delim++;
      sum = rx_window[1] + rx_window[2] + rx_window[3] + rx_window[4];
      if (rx_window[5] == sum) begin
        r.checksum_good = 1'b1;
        n_good++;
        if (rx_window[2] >= 8 && rx_window[2] <= 13) begin
          slot = int'(rx_window[2]) - 8;
        end else if (rx_window[2] >= 16 && rx_window[2] <= 18) begin
          slot = int'(rx_window[2]) - 10;
        end
        if (rx_window[1] == tfd_pkg::CmdWrite && slot >= 0) begin
          val = {rx_window[4], rx_window[3]};
          // input voltage over the limit is forced to zero
          if (slot == 0 && val > vin_limit) begin
            val = '0;
            n_clip++;
          end
          r.write_valid = 1'b1;
          r.target_slot = 4'(slot);
          r.slot_value = val;
          n_write++;
        end
      end
    end
    for (int i = 0; i < 5; i++) rx_window[i] = rx_window[i + 1];
    rx_window[5] = rx;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    error_count++;
    if (error_count <= 30) begin
      $display("[%0t] word %0d: %s got 0x%0h want 0x%0h", $realtime, words_checked,
               what, got, want);
    end
  endtask

  task automatic add_frame(input logic [7:0] cmd, input logic [7:0] addr,
                           input logic [7:0] lo, input logic [7:0] hi, input bit corrupt);
    logic [7:0] chk;
    chk = cmd + addr + lo + hi;
    if (corrupt) chk = chk ^ (8'd1 << $urandom_range(0, 7));
    pending_bytes.push_back(tfd_pkg::DelimStart);
    pending_bytes.push_back(cmd);
    pending_bytes.push_back(addr);
    pending_bytes.push_back(lo);
    pending_bytes.push_back(hi);
    pending_bytes.push_back(chk);
    pending_bytes.push_back(tfd_pkg::DelimEnd);
  endtask

  task automatic add_random_frame();
    logic [7:0]  cmd;
    logic [7:0]  addr;
    logic [15:0] val;
    int unsigned pick;
    int          v;
    // noise, sometimes holding delimiter values
    if ($urandom_range(0, 99) < 20) begin
      repeat ($urandom_range(1, 5)) begin
        pick = $urandom_range(0, 9);
        pending_bytes.push_back(pick == 0 ? tfd_pkg::DelimStart :
                                pick == 1 ? tfd_pkg::DelimEnd : 8'($urandom));
      end
    end
    // truncated frame
    if ($urandom_range(0, 99) < 5) begin
      pending_bytes.push_back(tfd_pkg::DelimStart);
      repeat ($urandom_range(1, 5)) pending_bytes.push_back(8'($urandom));
    end
    pick = $urandom_range(0, 99);
    cmd = (pick < 80) ? tfd_pkg::CmdWrite : 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 75) addr = 8'($urandom_range(8, 18));
    else if (pick < 85) addr = 8'($urandom_range(14, 15));
    else addr = 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 5) val = 16'h0000;
    else if (pick < 10) val = 16'hFFFF;
    else val = 16'($urandom);
    if (addr == 8 && $urandom_range(0, 1) == 1) begin
      v = int'(vin_limit) + int'($urandom_range(0, 4)) - 2;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      val = 16'(v);
    end
    add_frame(cmd, addr, val[7:0], val[15:8], $urandom_range(0, 9) == 0);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_bytes.size() != 0 || s_axis_tvalid || frame_results.size() != 0);
  endtask

  task automatic set_volt_limit(input logic [15:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    vin_limit = v;
    n_limits++;
    @(negedge clk);
  endtask

  task automatic run_random(input logic [15:0] limit, input int unsigned pct,
                            input int unsigned n);
    wait_drained();
    repeat (3) @(negedge clk);
    set_volt_limit(limit);
    idle_pct = pct;
    while (pending_bytes.size() < n) add_random_frame();
  endtask

  // byte driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      src_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        frame_results.push_back(deframe_byte(s_axis_tdata));
        bytes_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap != 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_bytes.size() == 0) begin
          s_axis_tvalid <= 1'b0;
        end else if ($urandom_range(0, 99) < idle_pct) begin
          src_gap = $urandom_range(0, 6);
          s_axis_tvalid <= 1'b0;
        end else begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= pending_bytes.pop_front();
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      sink_gap = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (frame_results.size() == 0) begin
          report_mismatch("word with nothing expected", m_axis_tdata, 0);
        end else begin
          want_word = frame_results.pop_front();
          if (m_axis_tuser[0] !== want_word.delimiters_found)
            report_mismatch("delimiters_found", m_axis_tuser[0], want_word.delimiters_found);
          if (m_axis_tuser[1] !== want_word.checksum_good)
            report_mismatch("checksum_good", m_axis_tuser[1], want_word.checksum_good);
          if (m_axis_tuser[2] !== want_word.write_valid)
            report_mismatch("write_valid", m_axis_tuser[2], want_word.write_valid);
          if (m_axis_tdata[3:0] !== want_word.target_slot)
            report_mismatch("target_slot", m_axis_tdata[3:0], want_word.target_slot);
          if (m_axis_tdata[19:4] !== want_word.slot_value)
            report_mismatch("slot_value", m_axis_tdata[19:4], want_word.slot_value);
        end
        words_checked++;
      end
      if (sink_gap != 0) begin
        sink_gap--;
        m_axis_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < idle_pct) begin
        sink_gap = $urandom_range(0, 6);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    // reset limit: voltage at the limit, just above it, bad checksum,
    // foreign command on an unmapped address
    add_frame(tfd_pkg::CmdWrite, 8'd8, 8'h70, 8'h17, 1'b0);
    add_frame(tfd_pkg::CmdWrite, 8'd8, 8'h71, 8'h17, 1'b0);
    add_frame(tfd_pkg::CmdWrite, 8'd11, 8'hFF, 8'hFF, 1'b1);
    add_frame(8'hFF, 8'd14, 8'h00, 8'h80, 1'b0);
    run_random(16'hFFFF, 30, 320);
    run_random(16'h0000, 15, 320);
    run_random(16'($urandom), 0, 320);
    run_random(tfd_pkg::VoltLimitReset, 40, 320);
    run_random(16'($urandom), 0, 320);
    wait_drained();
    repeat (8) @(posedge clk);
    $display("covered %0d bytes: %0d delimited windows, %0d good checksums, %0d slot writes",
             bytes_taken, n_delim, n_good, n_write);
    $display("%0d voltage clips over %0d limit settings including 0 and 65535",
             n_clip, n_limits);
    if (error_count == 0) begin
      $display("telemetry_frame_deframer_unit_tb: done, clean");
    end else begin
      $display("telemetry_frame_deframer_unit_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("timeout after %0d bytes and %0d words", bytes_taken, words_checked);
    $display("telemetry_frame_deframer_unit_tb: done, errors");
    $finish;
  end

endmodule
